@@ hw/rtl/vtpy_pkg.sv @@
// Shared types, constants and the arctangent table for the pitch and yaw pipeline.
package vtpy_pkg;

  localparam int DW = 60;
  localparam int AW = 26;
  localparam int GAIN_W = 22;
  localparam int ANG_W = 16;
  localparam int TBL_LEN = 24;

  localparam logic signed [AW-1:0] ANG_PI = AW'(8388608);
  localparam logic signed [AW-1:0] ANG_ROUND = AW'(128);
  localparam logic signed [AW-1:0] PITCH_LIM = AW'(16384);
  localparam logic signed [GAIN_W-1:0] GAIN_Q20 = GAIN_W'(1726753);
  localparam logic signed [ANG_W-1:0] PITCH_UP = -16'sd16384;
  localparam logic signed [ANG_W-1:0] PITCH_DOWN = 16'sd16384;

  typedef struct packed {
    logic             zero_xy;
    logic             z_pos;
    logic             z_neg;
    logic [ANG_W-1:0] default_yaw;
  } side_t;

  function automatic logic signed [AW-1:0] atan_ang(input int idx);
    logic signed [AW-1:0] val;
    unique case (idx)
      0:       val = AW'(2097152);
      1:       val = AW'(1238021);
      2:       val = AW'(654136);
      3:       val = AW'(332050);
      4:       val = AW'(166669);
      5:       val = AW'(83416);
      6:       val = AW'(41718);
      7:       val = AW'(20860);
      8:       val = AW'(10430);
      9:       val = AW'(5215);
      10:      val = AW'(2608);
      11:      val = AW'(1304);
      12:      val = AW'(652);
      13:      val = AW'(326);
      14:      val = AW'(163);
      15:      val = AW'(81);
      16:      val = AW'(41);
      17:      val = AW'(20);
      18:      val = AW'(10);
      19:      val = AW'(5);
      20:      val = AW'(3);
      21:      val = AW'(1);
      22:      val = AW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/vtpy_prep.sv @@
// Input stage: scales x and y, folds the left half plane and multiplies z by the gain.
module vtpy_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                en,
  input  logic                                                in_valid,
  input  logic signed [COORD_WIDTH-1:0]                       in_vec_x,
  input  logic signed [COORD_WIDTH-1:0]                       in_vec_y,
  input  logic signed [COORD_WIDTH-1:0]                       in_vec_z,
  input  logic signed [vtpy_pkg::ANG_W-1:0]                   in_default_yaw,
  output logic                                                out_valid,
  output logic signed [vtpy_pkg::DW-1:0]                      out_x,
  output logic signed [vtpy_pkg::DW-1:0]                      out_y,
  output logic signed [vtpy_pkg::AW-1:0]                      out_ang,
  output logic signed [COORD_WIDTH+vtpy_pkg::GAIN_W-1:0]      out_zprod,
  output vtpy_pkg::side_t                                     out_side
);

  localparam int DW = vtpy_pkg::DW;
  localparam int PRE_SHIFT = 56 - COORD_WIDTH;
  localparam int ZPW = COORD_WIDTH + vtpy_pkg::GAIN_W;

  logic signed [DW-1:0]  x_ext;
  logic signed [DW-1:0]  y_ext;
  logic signed [DW-1:0]  x_nxt;
  logic signed [DW-1:0]  y_nxt;
  logic signed [vtpy_pkg::AW-1:0] ang_nxt;
  logic signed [ZPW-1:0] zprod_nxt;
  vtpy_pkg::side_t       side_nxt;

  logic                  valid_r;
  logic signed [DW-1:0]  x_r;
  logic signed [DW-1:0]  y_r;
  logic signed [vtpy_pkg::AW-1:0] ang_r;
  logic signed [ZPW-1:0] zprod_r;
  vtpy_pkg::side_t       side_r;

  assign x_ext = {{(DW-COORD_WIDTH){in_vec_x[COORD_WIDTH-1]}}, in_vec_x} <<< PRE_SHIFT;
  assign y_ext = {{(DW-COORD_WIDTH){in_vec_y[COORD_WIDTH-1]}}, in_vec_y} <<< PRE_SHIFT;

  always_comb begin
    if (in_vec_x[COORD_WIDTH-1]) begin
      x_nxt = -x_ext;
      y_nxt = -y_ext;
      ang_nxt = vtpy_pkg::ANG_PI;
    end else begin
      x_nxt = x_ext;
      y_nxt = y_ext;
      ang_nxt = '0;
    end
    zprod_nxt = ZPW'(in_vec_z) * ZPW'(vtpy_pkg::GAIN_Q20);
    side_nxt.zero_xy = (in_vec_x == '0) && (in_vec_y == '0);
    side_nxt.z_pos = !in_vec_z[COORD_WIDTH-1] && (in_vec_z != '0);
    side_nxt.z_neg = in_vec_z[COORD_WIDTH-1];
    side_nxt.default_yaw = in_default_yaw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      ang_r <= ang_nxt;
      zprod_r <= zprod_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x = x_r;
  assign out_y = y_r;
  assign out_ang = ang_r;
  assign out_zprod = zprod_r;
  assign out_side = side_r;

endmodule

@@ hw/rtl/vtpy_cordic.sv @@
// Pipelined CORDIC vectoring pass with one registered micro-rotation per stage.
module vtpy_cordic #(
  parameter int STAGES = 16,
  parameter int AUX_W = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [vtpy_pkg::DW-1:0] in_x,
  input  logic signed [vtpy_pkg::DW-1:0] in_y,
  input  logic signed [vtpy_pkg::AW-1:0] in_ang,
  input  logic [AUX_W-1:0]               in_aux,
  output logic                           out_valid,
  output logic signed [vtpy_pkg::DW-1:0] out_x,
  output logic signed [vtpy_pkg::AW-1:0] out_ang,
  output logic [AUX_W-1:0]               out_aux
);

  localparam int DW = vtpy_pkg::DW;
  localparam int AW = vtpy_pkg::AW;

  logic [STAGES-1:0]    valid_r;
  logic signed [DW-1:0] x_r   [STAGES];
  logic signed [DW-1:0] y_r   [STAGES];
  logic signed [AW-1:0] ang_r [STAGES];
  logic [AUX_W-1:0]     aux_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                 v_in;
    logic signed [DW-1:0] x_in;
    logic signed [DW-1:0] y_in;
    logic signed [AW-1:0] ang_in;
    logic [AUX_W-1:0]     aux_in;
    logic signed [DW-1:0] x_nxt;
    logic signed [DW-1:0] y_nxt;
    logic signed [AW-1:0] ang_nxt;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = in_x;
      assign y_in = in_y;
      assign ang_in = in_ang;
      assign aux_in = in_aux;
    end else begin : g_next
      assign v_in = valid_r[i-1];
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign ang_in = ang_r[i-1];
      assign aux_in = aux_r[i-1];
    end

    always_comb begin
      if (!y_in[DW-1]) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        ang_nxt = ang_in + vtpy_pkg::atan_ang(i);
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        ang_nxt = ang_in - vtpy_pkg::atan_ang(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
      if (en && v_in) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        ang_r[i] <= ang_nxt;
        aux_r[i] <= aux_in;
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_x = x_r[STAGES-1];
  assign out_ang = ang_r[STAGES-1];
  assign out_aux = aux_r[STAGES-1];

endmodule

@@ hw/rtl/vtpy_out.sv @@
// Output stage: rounds and clamps the angles, handles the zero case and holds results.
module vtpy_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [vtpy_pkg::AW-1:0]    in_ang,
  input  logic signed [vtpy_pkg::ANG_W-1:0] in_yaw,
  input  vtpy_pkg::side_t                   in_side,
  input  logic                              out_stall,
  output logic                              en,
  output logic                              out_valid,
  output logic signed [vtpy_pkg::ANG_W-1:0] out_pitch_angle,
  output logic signed [vtpy_pkg::ANG_W-1:0] out_yaw_angle
);

  localparam int AW = vtpy_pkg::AW;
  localparam int ANG_W = vtpy_pkg::ANG_W;

  logic signed [AW-1:0]    rnd;
  logic signed [AW-1:0]    neg;
  logic signed [ANG_W-1:0] res_pitch;
  logic signed [ANG_W-1:0] res_yaw;
  logic                    take;

  logic                    out_v_r;
  logic                    out_v_nxt;
  logic                    skid_v_r;
  logic                    skid_v_nxt;
  logic signed [ANG_W-1:0] out_pitch_r;
  logic signed [ANG_W-1:0] out_yaw_r;
  logic signed [ANG_W-1:0] skid_pitch_r;
  logic signed [ANG_W-1:0] skid_yaw_r;

  always_comb begin
    rnd = (in_ang + vtpy_pkg::ANG_ROUND) >>> 8;
    neg = -rnd;
    priority if (in_side.zero_xy) begin
      if (in_side.z_pos) begin
        res_pitch = vtpy_pkg::PITCH_UP;
      end else if (in_side.z_neg) begin
        res_pitch = vtpy_pkg::PITCH_DOWN;
      end else begin
        res_pitch = '0;
      end
    end else if (neg > vtpy_pkg::PITCH_LIM) begin
      res_pitch = vtpy_pkg::PITCH_DOWN;
    end else if (neg < -vtpy_pkg::PITCH_LIM) begin
      res_pitch = vtpy_pkg::PITCH_UP;
    end else begin
      res_pitch = neg[ANG_W-1:0];
    end
    res_yaw = in_side.zero_xy ? in_side.default_yaw : in_yaw;
  end

  assign take = out_v_r && !out_stall;
  assign en = !skid_v_r;

  always_comb begin
    out_v_nxt = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (take) begin
        skid_v_nxt = 1'b0;
      end
    end else if (in_valid) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    if (skid_v_r) begin
      if (take) begin
        out_pitch_r <= skid_pitch_r;
        out_yaw_r <= skid_yaw_r;
      end
    end else if (in_valid) begin
      if (!out_v_r || take) begin
        out_pitch_r <= res_pitch;
        out_yaw_r <= res_yaw;
      end else begin
        skid_pitch_r <= res_pitch;
        skid_yaw_r <= res_yaw;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle = out_yaw_r;

endmodule

@@ hw/rtl/vector_to_pitch_yaw.sv @@
// Top level: yaw and pitch of a 3D direction vector through two chained CORDIC pipelines.
// The pipeline is one input stage, one register per micro-rotation in each of the two
// vectoring passes, and one output register.
// Throughput is one item per cycle while in_stall is low; a skid register behind the output lets the pipeline
// advance while a result waits, and in_stall rises only once that skid register is full.
// Synchronous active-low reset clears the valid bits only; data registers keep their contents.
module vector_to_pitch_yaw #(
  parameter int COORD_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_vec_x,
  input  logic signed [COORD_WIDTH-1:0]     in_vec_y,
  input  logic signed [COORD_WIDTH-1:0]     in_vec_z,
  input  logic signed [vtpy_pkg::ANG_W-1:0] in_default_yaw,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vtpy_pkg::ANG_W-1:0] out_pitch_angle,
  output logic signed [vtpy_pkg::ANG_W-1:0] out_yaw_angle
);

  localparam int DW = vtpy_pkg::DW;
  localparam int AW = vtpy_pkg::AW;
  localparam int ANG_W = vtpy_pkg::ANG_W;
  localparam int ZPW = COORD_WIDTH + vtpy_pkg::GAIN_W;
  localparam int Z_SHIFT = 56 - COORD_WIDTH - 20;
  localparam int SIDE_W = $bits(vtpy_pkg::side_t);
  localparam int AUX1_W = SIDE_W + ZPW;
  localparam int AUX2_W = SIDE_W + ANG_W;

  logic                  en;

  logic                  p0_valid;
  logic signed [DW-1:0]  p0_x;
  logic signed [DW-1:0]  p0_y;
  logic signed [AW-1:0]  p0_ang;
  logic signed [ZPW-1:0] p0_zprod;
  vtpy_pkg::side_t       p0_side;

  logic                  p1_valid;
  logic signed [DW-1:0]  p1_x;
  logic signed [AW-1:0]  p1_ang;
  logic [AUX1_W-1:0]     p1_aux;
  vtpy_pkg::side_t       p1_side;
  logic signed [ZPW-1:0] p1_zprod;
  logic signed [DW-1:0]  p1_z;
  logic signed [AW-1:0]  p1_yaw_rnd;

  logic                  p2_valid;
  logic signed [DW-1:0]  p2_x;
  logic signed [AW-1:0]  p2_ang;
  logic [AUX2_W-1:0]     p2_aux;
  vtpy_pkg::side_t       p2_side;
  logic signed [ANG_W-1:0] p2_yaw;

  vtpy_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_default_yaw(in_default_yaw),
    .out_valid     (p0_valid),
    .out_x         (p0_x),
    .out_y         (p0_y),
    .out_ang       (p0_ang),
    .out_zprod     (p0_zprod),
    .out_side      (p0_side)
  );

  vtpy_cordic #(
    .STAGES(CORDIC_STAGES),
    .AUX_W (AUX1_W)
  ) u_yaw_pass (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p0_valid),
    .in_x     (p0_x),
    .in_y     (p0_y),
    .in_ang   (p0_ang),
    .in_aux   ({p0_side, p0_zprod}),
    .out_valid(p1_valid),
    .out_x    (p1_x),
    .out_ang  (p1_ang),
    .out_aux  (p1_aux)
  );

  assign p1_side = p1_aux[AUX1_W-1:ZPW];
  assign p1_zprod = p1_aux[ZPW-1:0];
  assign p1_z = {{(DW-ZPW){p1_zprod[ZPW-1]}}, p1_zprod} <<< Z_SHIFT;
  assign p1_yaw_rnd = p1_ang + vtpy_pkg::ANG_ROUND;

  vtpy_cordic #(
    .STAGES(CORDIC_STAGES),
    .AUX_W (AUX2_W)
  ) u_pitch_pass (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p1_valid),
    .in_x     (p1_x),
    .in_y     (p1_z),
    .in_ang   ('0),
    .in_aux   ({p1_side, p1_yaw_rnd[ANG_W+7:8]}),
    .out_valid(p2_valid),
    .out_x    (p2_x),
    .out_ang  (p2_ang),
    .out_aux  (p2_aux)
  );

  assign p2_side = p2_aux[AUX2_W-1:ANG_W];
  assign p2_yaw = p2_aux[ANG_W-1:0];

  vtpy_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (p2_valid && (p2_x == p2_x)),
    .in_ang         (p2_ang),
    .in_yaw         (p2_yaw),
    .in_side        (p2_side),
    .out_stall      (out_stall),
    .en             (en),
    .out_valid      (out_valid),
    .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle  (out_yaw_angle)
  );

  assign in_stall = !en;

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle >= vtpy_pkg::PITCH_UP &&
                   out_pitch_angle <= vtpy_pkg::PITCH_DOWN))
    else $error("pitch angle outside the quarter-turn range");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("pipeline froze without a stalled result");

endmodule

@@ sim/vector_to_pitch_yaw_test.sv @@
// Testbench for vector_to_pitch_yaw: directed and random vectors checked against a predictor or listed angles.
`timescale 1ns / 1ps

module vector_to_pitch_yaw_test;

  localparam int STAGES = 16;
  localparam int PRE_SHIFT = 40;
  localparam longint Z_GAIN = 1726753;
  localparam longint HALF_TURN = 8388608;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 2 * STAGES + 8;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] dyaw;
    logic               known;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } vec_row_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  typedef struct {
    longint mag;
    longint ang;
  } cordic_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_vec_x = '0;
  logic signed [15:0] in_vec_y = '0;
  logic signed [15:0] in_vec_z = '0;
  logic signed [15:0] in_default_yaw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;

  longint arc_tab [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                           10430, 5215, 2608, 1304, 652, 326, 163, 81};

  vec_row_t vectors [$];
  angles_t due_angles [$];
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  bit squeeze = 1'b0;
  bit steady = 1'b0;

  vector_to_pitch_yaw DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_vec_x(in_vec_x),
    .in_vec_y(in_vec_y),
    .in_vec_z(in_vec_z),
    .in_default_yaw(in_default_yaw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle)
  );

  always #2 clk = ~clk;

  function automatic cordic_t vector_pass(input longint a, input longint b, input longint ang);
    cordic_t res;
    longint da;
    longint db;
    for (int k = 0; k < STAGES; k++) begin
      da = b >>> k;
      db = a >>> k;
      if (b >= 0) begin
        a = a + da;
        b = b - db;
        ang = ang + arc_tab[k];
      end else begin
        a = a - da;
        b = b + db;
        ang = ang - arc_tab[k];
      end
    end
    res.mag = a;
    res.ang = ang;
    return res;
  endfunction

  function automatic angles_t pitch_yaw_of(input vec_row_t v);
    angles_t r;
    cordic_t flat;
    cordic_t tilt;
    longint xs;
    longint ys;
    longint zs;
    longint turn;
    longint p;
    xs = longint'(v.vx);
    ys = longint'(v.vy);
    zs = longint'(v.vz);
    if (xs == 0 && ys == 0) begin
      r.yaw = v.dyaw;
      if (zs > 0) begin
        r.pitch = vtpy_pkg::PITCH_UP;
      end else if (zs < 0) begin
        r.pitch = vtpy_pkg::PITCH_DOWN;
      end else begin
        r.pitch = '0;
      end
      return r;
    end
    xs = xs <<< PRE_SHIFT;
    ys = ys <<< PRE_SHIFT;
    zs = (zs * Z_GAIN) <<< (PRE_SHIFT - 20);
    turn = 0;
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      turn = HALF_TURN;
    end
    flat = vector_pass(xs, ys, turn);
    r.yaw = 16'((flat.ang + 128) >>> 8);
    tilt = vector_pass(flat.mag, zs, 0);
    p = -((tilt.ang + 128) >>> 8);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    r.pitch = 16'(p);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic vec_row_t vrow(input int x, input int y, input int z, input int d,
                                    input bit k = 1'b0, input int p = 0, input int w = 0);
    vec_row_t v;
    v.vx = 16'(x);
    v.vy = 16'(y);
    v.vz = 16'(z);
    v.dyaw = 16'(d);
    v.known = k;
    v.pitch = 16'(p);
    v.yaw = 16'(w);
    return v;
  endfunction

  function automatic int near_edge();
    int off;
    off = $urandom_range(0, 255);
    return $urandom_range(0, 1) ? -32768 + off : 32767 - off;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_angles.size() == 0) begin
        $display("%0t: unexpected result, pitch %0d yaw %0d", $time, out_pitch_angle,
                 out_yaw_angle);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = due_angles.pop_front();
        if (out_pitch_angle !== want.pitch) begin
          $display("%0t: pitch mismatch, expected %0d, got %0d", $time, want.pitch,
                   out_pitch_angle);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (out_yaw_angle !== want.yaw) begin
          $display("%0t: yaw mismatch, expected %0d, got %0d", $time, want.yaw, out_yaw_angle);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  initial begin
    bit held;
    int n;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (!squeeze) held = 1'b0;
        n = steady ? 0 : pick_gap();
        out_stall <= (n != 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    int r;
    int gap;
    int x;
    int y;
    int z;
    angles_t want;

    // Zero horizontal part first: pitch is set by the sign of z and yaw is the default; then other vectors.
    vectors.push_back(vrow(0, 0, 0, 0, 1'b1, 0, 0));
    vectors.push_back(vrow(0, 0, 1, 32767, 1'b1, -16384, 32767));
    vectors.push_back(vrow(0, 0, -1, -32768, 1'b1, 16384, -32768));
    vectors.push_back(vrow(0, 0, 32767, 21845, 1'b1, -16384, 21845));
    vectors.push_back(vrow(0, 0, -32768, -21846, 1'b1, 16384, -21846));
    vectors.push_back(vrow(32767, 0, 0, 0));
    vectors.push_back(vrow(-32768, 0, 0, 0));
    vectors.push_back(vrow(0, 32767, 0, 0));
    vectors.push_back(vrow(0, -32768, 0, 0));
    vectors.push_back(vrow(-1, 0, 0, 0));
    vectors.push_back(vrow(-32768, 1, 0, 0));
    vectors.push_back(vrow(-32768, -1, 0, 0));
    vectors.push_back(vrow(32767, 32767, 32767, 0));
    vectors.push_back(vrow(-32768, -32768, -32768, 0));
    vectors.push_back(vrow(1, 0, 32767, 0));
    vectors.push_back(vrow(0, 1, -32768, 0));
    vectors.push_back(vrow(-1, -1, 32767, 0));
    vectors.push_back(vrow(1, 1, 1, 0));
    vectors.push_back(vrow(32767, -32768, -32768, 0));
    vectors.push_back(vrow(-32768, 32767, 32767, -1));
    vectors.push_back(vrow(32767, 32767, -32768, 0));
    vectors.push_back(vrow(0, -1, 0, 12345));
    vectors.push_back(vrow(-21846, 21845, -1, 0));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
      z = $signed(16'($urandom));
      if (r < 45) begin
      end else if (r < 60) begin
        x = $urandom_range(0, 16) - 8;
        y = $urandom_range(0, 16) - 8;
        z = $urandom_range(0, 16) - 8;
      end else if (r < 70) begin
        x = 0;
        y = 0;
      end else if (r < 80) begin
        if ($urandom_range(0, 1)) x = 0;
        else y = 0;
      end else if (r < 90) begin
        x = near_edge();
        y = near_edge();
        z = near_edge();
      end else begin
        x = $urandom_range(0, 4) - 2;
        y = $urandom_range(0, 4) - 2;
        z = near_edge();
      end
      vectors.push_back(vrow(x, y, z, $signed(16'($urandom))));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < vectors.size(); i++) begin
      squeeze = (i >= 600 && i < 800) || (i >= 1300 && i < 1450);
      steady = (i >= 1000 && i < 1200);
      gap = (squeeze || steady) ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_vec_x <= vectors[i].vx;
      in_vec_y <= vectors[i].vy;
      in_vec_z <= vectors[i].vz;
      in_default_yaw <= vectors[i].dyaw;
      do @(posedge clk); while (in_stall);
      if (vectors[i].known) begin
        want.pitch = vectors[i].pitch;
        want.yaw = vectors[i].yaw;
      end else begin
        want = pitch_yaw_of(vectors[i]);
      end
      due_angles.push_back(want);
    end
    squeeze = 1'b0;
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
